[rtl/bls_pkg.sv]
// Package for the buzzer and LED priority sequencer.
// Holds the item types, action codes, timing constants and the song ROM contents.
// No dependencies.
package bls_pkg;

   typedef struct packed {
      logic [2:0]  action;
      logic [14:0] blink_half_period;
      logic [2:0]  song_number;
      logic        error_mode;
   } bls_req_type;

   typedef struct packed {
      logic        led;
      logic [10:0] tone_hz;
      logic        sound_active;
   } bls_rsp_type;

   // One ROM row: the step itself plus the precomputed buzzer length
   typedef struct packed {
      logic        note;
      logic [10:0] freq;
      logic [10:0] dur;
      logic [10:0] tone_ms;
   } bls_row_type;

   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_LED_ON    = 3'd1;
   localparam logic [2:0] ACT_LED_OFF   = 3'd2;
   localparam logic [2:0] ACT_BLINK_ON  = 3'd3;
   localparam logic [2:0] ACT_BLINK_OFF = 3'd4;
   localparam logic [2:0] ACT_BEEP      = 3'd5;

   localparam logic [2:0]  SONG_NONE      = 3'd7;
   localparam logic [10:0] LONG_TONE_MS   = 11'd2000;
   localparam logic [15:0] ERROR_BLINK_MS = 16'd50;
   localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

   function automatic bls_row_type bls_step(input logic [10:0] f, input logic [10:0] d);
      bls_row_type r;
      r.note    = 1'b1;
      r.freq    = f;
      r.dur     = d;
      r.tone_ms = '0;
      return r;
   endfunction

   // Raw tone sequences; rows not listed are end markers
   function automatic bls_row_type bls_rom_raw(input int idx);
      bls_row_type r;
      r = '0;
      case (idx)
         0:  r = bls_step(11'd440, 11'd50);
         1:  r = bls_step(11'd659, 11'd50);
         3:  r = bls_step(11'd554, 11'd50);
         4:  r = bls_step(11'd659, 11'd50);
         5:  r = bls_step(11'd880, 11'd100);
         7:  r = bls_step(11'd659, 11'd100);
         9:  r = bls_step(11'd200, 11'd100);
         10: r = bls_step(11'd0, 11'd50);
         11: r = bls_step(11'd200, 11'd100);
         13: r = bls_step(11'd200, 11'd100);
         14: r = bls_step(11'd0, 11'd50);
         15: r = bls_step(11'd200, 11'd100);
         16: r = bls_step(11'd0, 11'd50);
         17: r = bls_step(11'd200, 11'd1000);
         19: r = bls_step(11'd440, 11'd50);
         20: r = bls_step(11'd554, 11'd50);
         21: r = bls_step(11'd659, 11'd50);
         22: r = bls_step(11'd880, 11'd50);
         23: r = bls_step(11'd1108, 11'd50);
         24: r = bls_step(11'd1319, 11'd50);
         25: r = bls_step(11'd1760, 11'd100);
         27: r = bls_step(11'd1760, 11'd50);
         28: r = bls_step(11'd1319, 11'd50);
         29: r = bls_step(11'd1108, 11'd50);
         30: r = bls_step(11'd880, 11'd50);
         31: r = bls_step(11'd659, 11'd50);
         32: r = bls_step(11'd554, 11'd50);
         33: r = bls_step(11'd440, 11'd100);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Row as seen through a ROM of the given depth, with the tone length folded in:
   // a tone followed by another tone holds the long length
   function automatic bls_row_type bls_rom_row(input int idx, input int depth);
      bls_row_type s;
      bls_row_type nx;
      s  = (idx < depth) ? bls_rom_raw(idx) : '0;
      nx = ((idx + 1) < depth) ? bls_rom_raw(idx + 1) : '0;
      s.tone_ms = (nx.note && (nx.freq != '0)) ? LONG_TONE_MS : s.dur;
      return s;
   endfunction

   function automatic logic [7:0] bls_song_start(input logic [2:0] song);
      logic [7:0] r;
      case (song)
         3'd0:    r = 8'd0;
         3'd1:    r = 8'd3;
         3'd2:    r = 8'd7;
         3'd3:    r = 8'd9;
         3'd4:    r = 8'd13;
         3'd5:    r = 8'd19;
         3'd6:    r = 8'd27;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

endpackage

[rtl/buzzer_led_priority_sequencer_top.sv]
// Top level of the buzzer and LED priority sequencer.
// Depends on bls_pkg, bls_song_rom and bls_ctrl.

// Takes one event item per clock cycle when not stalled and returns one result item
// for each in the cycle after acceptance, holding it in an output register while
// rsp_stall is high; req_stall follows rsp_stall only while that register is full.
// Each cycle the song ROM reads, on its two ports, the step now playing and the
// step after it for the step index that the item leaves behind, so the next tick
// finds both ready. There is no clearing pass after reset: the ROM is constant.
module buzzer_led_priority_sequencer_top #(
   parameter int SONG_ROM_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bls_pkg::bls_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bls_pkg::bls_rsp_type  rsp_data
);
   import bls_pkg::*;

   localparam int AW = $clog2(SONG_ROM_DEPTH);

   logic          req_accept;
   logic [AW:0]   rd_addr_a;
   logic [AW:0]   rd_addr_b;
   bls_row_type   row_cur;
   bls_row_type   row_nxt;
   bls_rsp_type   rsp_next;
   logic          rsp_valid_ff, rsp_valid_in;
   bls_rsp_type   rsp_data_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   bls_song_rom #(
      .DEPTH (SONG_ROM_DEPTH)
   ) u_rom (
      .clock     (clock),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (row_cur),
      .rd_data_b (row_nxt)
   );

   bls_ctrl #(
      .DEPTH (SONG_ROM_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .row_cur    (row_cur),
      .row_nxt    (row_nxt),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rsp_next   (rsp_next)
   );

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result with the item; hold it while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/bls_song_rom.sv]
// Synchronous song ROM with two read ports and registered read data.
// Depends on bls_pkg for the row type and contents.
module bls_song_rom #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic [$clog2(DEPTH):0]      rd_addr_a,
   input  logic [$clog2(DEPTH):0]      rd_addr_b,
   output bls_pkg::bls_row_type        rd_data_a,
   output bls_pkg::bls_row_type        rd_data_b
);
   import bls_pkg::*;

   bls_row_type rd_data_a_ff;
   bls_row_type rd_data_b_ff;

   // Addresses at or past the depth read as an end marker
   always_ff @(posedge clock) begin
      rd_data_a_ff <= bls_rom_row(int'(rd_addr_a), DEPTH);
      rd_data_b_ff <= bls_rom_row(int'(rd_addr_b), DEPTH);
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[rtl/bls_ctrl.sv]
// Event handling and sequencer state for the buzzer and LED block.
// Depends on bls_pkg; reads the current and following song steps from bls_song_rom.
module bls_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_accept,
   input  bls_pkg::bls_req_type        req_data,
   input  bls_pkg::bls_row_type        row_cur,
   input  bls_pkg::bls_row_type        row_nxt,
   output logic [$clog2(DEPTH):0]      rd_addr_a,
   output logic [$clog2(DEPTH):0]      rd_addr_b,
   output bls_pkg::bls_rsp_type        rsp_next
);
   import bls_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic          led_ff,           led_in;
   logic          default_level_ff, default_level_in;
   logic [14:0]   blink_period_ff,  blink_period_in;
   logic [15:0]   blink_elapsed_ff, blink_elapsed_in;
   logic          playing_ff,       playing_in;
   logic          error_blink_ff,   error_blink_in;
   logic [AW-1:0] step_ff,          step_in;
   logic [15:0]   note_elapsed_ff,  note_elapsed_in;
   logic [10:0]   freq_ff,          freq_in;
   logic [10:0]   tone_left_ff,     tone_left_in;

   logic [7:0]    beep_start;
   bls_row_type   beep_row;
   logic          beep_ok;

   assign beep_start = bls_song_start(req_data.song_number);
   assign beep_row   = bls_rom_row(int'(beep_start), DEPTH);
   assign beep_ok    = (req_data.song_number != SONG_NONE) && (int'(beep_start) < DEPTH)
                       && beep_row.note;

   always_comb begin
      led_in           = led_ff;
      default_level_in = default_level_ff;
      blink_period_in  = blink_period_ff;
      blink_elapsed_in = blink_elapsed_ff;
      playing_in       = playing_ff;
      error_blink_in   = error_blink_ff;
      step_in          = step_ff;
      note_elapsed_in  = note_elapsed_ff;
      freq_in          = freq_ff;
      tone_left_in     = tone_left_ff;
      if (req_accept) begin
         case (req_data.action) inside
            ACT_TICK: begin
               if (tone_left_ff != '0) begin
                  tone_left_in = tone_left_ff - 11'd1;
                  if (tone_left_in == '0) begin
                     freq_in = '0;
                  end
               end
               if (note_elapsed_ff != ELAPSED_MAX) begin
                  note_elapsed_in = note_elapsed_ff + 16'd1;
               end
               if (blink_elapsed_ff != ELAPSED_MAX) begin
                  blink_elapsed_in = blink_elapsed_ff + 16'd1;
               end
               if (playing_ff) begin
                  if (note_elapsed_in > {5'd0, row_cur.dur}) begin
                     step_in = step_ff + AW'(1);
                     if (row_nxt.note) begin
                        note_elapsed_in = '0;
                        // a rest leaves the buzzer alone
                        if (row_nxt.freq != '0) begin
                           freq_in      = (row_nxt.tone_ms == '0) ? '0 : row_nxt.freq;
                           tone_left_in = row_nxt.tone_ms;
                        end
                     end else begin
                        freq_in        = '0;
                        tone_left_in   = '0;
                        playing_in     = 1'b0;
                        error_blink_in = 1'b0;
                        if (blink_period_ff != '0) begin
                           led_in           = ~led_ff;
                           blink_elapsed_in = '0;
                        end else begin
                           led_in = default_level_ff;
                        end
                     end
                  end
                  if (error_blink_in && (blink_elapsed_in > ERROR_BLINK_MS)) begin
                     led_in           = ~led_in;
                     blink_elapsed_in = '0;
                  end
               end else if ((blink_period_ff != '0)
                            && (blink_elapsed_in > {1'b0, blink_period_ff})) begin
                  led_in           = ~led_ff;
                  blink_elapsed_in = '0;
               end
            end
            ACT_LED_ON, ACT_LED_OFF: begin
               default_level_in = (req_data.action == ACT_LED_ON);
               if ((blink_period_ff == '0) && !playing_ff) begin
                  led_in = default_level_in;
               end
            end
            ACT_BLINK_ON: begin
               blink_period_in = req_data.blink_half_period;
               if (!playing_ff) begin
                  led_in           = ~led_ff;
                  blink_elapsed_in = '0;
               end
            end
            ACT_BLINK_OFF: begin
               blink_period_in = '0;
               if (!playing_ff) begin
                  led_in = default_level_ff;
               end
            end
            ACT_BEEP: begin
               if (beep_ok) begin
                  error_blink_in  = req_data.error_mode;
                  playing_in      = 1'b1;
                  step_in         = beep_start[AW-1:0];
                  note_elapsed_in = '0;
                  if (beep_row.freq != '0) begin
                     freq_in      = (beep_row.tone_ms == '0) ? '0 : beep_row.freq;
                     tone_left_in = beep_row.tone_ms;
                  end
                  if (!req_data.error_mode) begin
                     led_in = 1'b0;
                  end else begin
                     led_in           = ~led_ff;
                     blink_elapsed_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff           <= 1'b0;
         default_level_ff <= 1'b0;
         blink_period_ff  <= '0;
         blink_elapsed_ff <= '0;
         playing_ff       <= 1'b0;
         error_blink_ff   <= 1'b0;
         step_ff          <= '0;
         note_elapsed_ff  <= '0;
         freq_ff          <= '0;
         tone_left_ff     <= '0;
      end else begin
         led_ff           <= led_in;
         default_level_ff <= default_level_in;
         blink_period_ff  <= blink_period_in;
         blink_elapsed_ff <= blink_elapsed_in;
         playing_ff       <= playing_in;
         error_blink_ff   <= error_blink_in;
         step_ff          <= step_in;
         note_elapsed_ff  <= note_elapsed_in;
         freq_ff          <= freq_in;
         tone_left_ff     <= tone_left_in;
      end
   end

   // Fetch the rows for the step that holds after this cycle
   assign rd_addr_a = {1'b0, step_in};
   assign rd_addr_b = {1'b0, step_in} + (AW + 1)'(1);

   assign rsp_next.led          = led_in;
   assign rsp_next.tone_hz      = freq_in;
   assign rsp_next.sound_active = playing_in;

`ifndef ASSERT_OFF
   a_silent_when_done: assert property (@(posedge clock) disable iff (reset)
      (tone_left_ff == '0) |-> (freq_ff == '0))
      else $error("buzzer sounds with no time left");
   a_error_needs_play: assert property (@(posedge clock) disable iff (reset)
      error_blink_ff |-> playing_ff)
      else $error("error blink active without playback");
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(note_elapsed_ff) && $stable(step_ff) && $stable(led_ff)))
      else $error("state moved without an item");
`endif

endmodule

[sim/tb_buzzer_led_priority_sequencer_top.sv]
// Self-checking testbench for the buzzer and LED priority sequencer.
// Predicts every result item from its own model of the LED priority and tone playback.
// Depends on bls_pkg and buzzer_led_priority_sequencer_top.
module tb_buzzer_led_priority_sequencer_top;
   import bls_pkg::*;

   localparam int ROM_DEPTH   = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_GOAL   = 1900;

   typedef struct packed {
      logic        drain;
      bls_req_type item;
   } queued_req_type;

   typedef struct packed {
      logic        note;
      logic [10:0] hz;
      logic [10:0] ms;
   } tune_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bls_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bls_rsp_type rsp_data;

   queued_req_type pending_q[$];
   bls_rsp_type    expected_q[$];

   int n_sent = 0;
   int n_recv = 0;
   int n_bad = 0;
   int n_cycles = 0;
   int n_fed = 0;
   int n_total = 0;
   bit pause_next = 1'b0;

   // Predicted state of the sequencer
   logic        led_now = 1'b0;
   logic        led_default = 1'b0;
   logic [14:0] blink_half = '0;
   logic [15:0] blink_ms = '0;
   logic        tune_on = 1'b0;
   logic        err_flash = 1'b0;
   logic [5:0]  tune_step = '0;
   logic [15:0] step_ms = '0;
   logic [10:0] buzz_hz = '0;
   logic [10:0] buzz_left = '0;

   wire calm = (n_sent >= 700) && (n_sent < 1000);

   buzzer_led_priority_sequencer_top #(
      .SONG_ROM_DEPTH(ROM_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic tune_row_type tone_rom(input int idx);
      tune_row_type r;
      r = '0;
      if (idx < ROM_DEPTH) begin
         case (idx)
            0:  r = '{1'b1, 11'd440, 11'd50};
            1:  r = '{1'b1, 11'd659, 11'd50};
            3:  r = '{1'b1, 11'd554, 11'd50};
            4:  r = '{1'b1, 11'd659, 11'd50};
            5:  r = '{1'b1, 11'd880, 11'd100};
            7:  r = '{1'b1, 11'd659, 11'd100};
            9:  r = '{1'b1, 11'd200, 11'd100};
            10: r = '{1'b1, 11'd0, 11'd50};
            11: r = '{1'b1, 11'd200, 11'd100};
            13: r = '{1'b1, 11'd200, 11'd100};
            14: r = '{1'b1, 11'd0, 11'd50};
            15: r = '{1'b1, 11'd200, 11'd100};
            16: r = '{1'b1, 11'd0, 11'd50};
            17: r = '{1'b1, 11'd200, 11'd1000};
            19: r = '{1'b1, 11'd440, 11'd50};
            20: r = '{1'b1, 11'd554, 11'd50};
            21: r = '{1'b1, 11'd659, 11'd50};
            22: r = '{1'b1, 11'd880, 11'd50};
            23: r = '{1'b1, 11'd1108, 11'd50};
            24: r = '{1'b1, 11'd1319, 11'd50};
            25: r = '{1'b1, 11'd1760, 11'd100};
            27: r = '{1'b1, 11'd1760, 11'd50};
            28: r = '{1'b1, 11'd1319, 11'd50};
            29: r = '{1'b1, 11'd1108, 11'd50};
            30: r = '{1'b1, 11'd880, 11'd50};
            31: r = '{1'b1, 11'd659, 11'd50};
            32: r = '{1'b1, 11'd554, 11'd50};
            33: r = '{1'b1, 11'd440, 11'd100};
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic int tune_first(input logic [2:0] song);
      case (song)
         3'd0:    return 0;
         3'd1:    return 3;
         3'd2:    return 7;
         3'd3:    return 9;
         3'd4:    return 13;
         3'd5:    return 19;
         default: return 27;
      endcase
   endfunction

   function automatic void flip_led();
      led_now = !led_now;
      blink_ms = '0;
   endfunction

   // A rest leaves the buzzer alone; a tone followed by a tone holds the long length
   function automatic void sound_step(input int idx);
      tune_row_type s;
      tune_row_type nx;
      s = tone_rom(idx);
      nx = tone_rom(idx + 1);
      if (s.hz != '0) begin
         buzz_hz = s.hz;
         buzz_left = (nx.note && nx.hz != '0) ? LONG_TONE_MS : s.ms;
         if (buzz_left == '0) buzz_hz = '0;
      end
   endfunction

   function automatic void end_tune();
      buzz_hz = '0;
      buzz_left = '0;
      tune_on = 1'b0;
      err_flash = 1'b0;
      if (blink_half != '0) flip_led();
      else led_now = led_default;
   endfunction

   function automatic void tick_ms();
      tune_row_type cur;
      if (buzz_left != '0) begin
         buzz_left = buzz_left - 1'b1;
         if (buzz_left == '0) buzz_hz = '0;
      end
      if (step_ms != ELAPSED_MAX) step_ms = step_ms + 1'b1;
      if (blink_ms != ELAPSED_MAX) blink_ms = blink_ms + 1'b1;
      if (tune_on) begin
         cur = tone_rom(int'(tune_step));
         if (step_ms > {5'd0, cur.ms}) begin
            tune_step = tune_step + 1'b1;
            if (tone_rom(int'(tune_step)).note) begin
               step_ms = '0;
               sound_step(int'(tune_step));
            end else begin
               end_tune();
            end
         end
         if (err_flash && blink_ms > ERROR_BLINK_MS) flip_led();
      end else if (blink_half != '0) begin
         if (blink_ms > {1'b0, blink_half}) flip_led();
      end
   endfunction

   function automatic void start_tune(input logic [2:0] song, input logic err);
      int idx;
      if (song == SONG_NONE) return;
      idx = tune_first(song);
      if (!tone_rom(idx).note) return;
      err_flash = err;
      tune_on = 1'b1;
      tune_step = idx[5:0];
      step_ms = '0;
      sound_step(idx);
      if (!err) led_now = 1'b0;
      else flip_led();
   endfunction

   function automatic bls_rsp_type predict_event(input bls_req_type it);
      bls_rsp_type r;
      case (it.action)
         ACT_TICK: tick_ms();
         ACT_LED_ON, ACT_LED_OFF: begin
            led_default = (it.action == ACT_LED_ON);
            if (blink_half == '0 && !tune_on) led_now = led_default;
         end
         ACT_BLINK_ON: begin
            blink_half = it.blink_half_period;
            if (!tune_on) flip_led();
         end
         ACT_BLINK_OFF: begin
            blink_half = '0;
            if (!tune_on) led_now = led_default;
         end
         ACT_BEEP: start_tune(it.song_number, it.error_mode);
         default: ;
      endcase
      r.led = led_now;
      r.tone_hz = buzz_hz;
      r.sound_active = tune_on;
      return r;
   endfunction

   task automatic queue_event(input logic [2:0] act, input int half, input int song,
                              input logic err);
      queued_req_type e;
      e.drain = pause_next;
      e.item.action = act;
      e.item.blink_half_period = half[14:0];
      e.item.song_number = song[2:0];
      e.item.error_mode = err;
      pending_q.push_back(e);
      pause_next = 1'b0;
      if (act <= ACT_BEEP && !(act == ACT_BEEP && song[2:0] == SONG_NONE)) n_fed++;
   endtask

   task automatic queue_tick();
      queue_event(ACT_TICK, $urandom_range(0, 32767), $urandom_range(0, 7),
                  1'($urandom_range(0, 1)));
   endtask

   // Interrupting event: LED level, blink change or a restarting beep
   task automatic queue_stray();
      case ($urandom_range(0, 4))
         0: queue_event(ACT_LED_ON, $urandom_range(0, 32767), $urandom_range(0, 7),
                        1'($urandom_range(0, 1)));
         1: queue_event(ACT_LED_OFF, $urandom_range(0, 32767), $urandom_range(0, 7),
                        1'($urandom_range(0, 1)));
         2: queue_event(ACT_BLINK_ON, $urandom_range(0, 30), $urandom_range(0, 7),
                        1'($urandom_range(0, 1)));
         3: queue_event(ACT_BLINK_OFF, $urandom_range(0, 32767), $urandom_range(0, 7),
                        1'($urandom_range(0, 1)));
         default: queue_event(ACT_BEEP, $urandom_range(0, 32767), $urandom_range(0, 6),
                              1'($urandom_range(0, 1)));
      endcase
   endtask

   always @(posedge clock) begin : req_driver
      logic took;
      logic go;
      queued_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         led_now = 1'b0;
         led_default = 1'b0;
         blink_half = '0;
         blink_ms = '0;
         tune_on = 1'b0;
         err_flash = 1'b0;
         tune_step = '0;
         step_ms = '0;
         buzz_hz = '0;
         buzz_left = '0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            expected_q.push_back(predict_event(req_data));
            n_sent <= n_sent + 1;
         end
         // hold a stalled item; otherwise pick the next one or idle
         if (!req_valid || took) begin
            go = (pending_q.size() != 0) && (calm || $urandom_range(0, 99) >= 26);
            if (go && pending_q[0].drain && (took || n_sent != n_recv)) go = 1'b0;
            if (go) begin
               nxt = pending_q.pop_front();
               req_data <= nxt.item;
            end
            req_valid <= go;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      bls_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_recv <= n_recv + 1;
            if (expected_q.size() == 0) begin
               if (n_bad < 10)
                  $display("item %0d unexpected: led %0b tone %0d active %0b",
                           n_recv, rsp_data.led, rsp_data.tone_hz, rsp_data.sound_active);
               n_bad++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.led !== want.led || rsp_data.tone_hz !== want.tone_hz ||
                   rsp_data.sound_active !== want.sound_active) begin
                  if (n_bad < 10)
                     $display("item %0d: expected led/tone/active %0b/%0d/%0b, got %0b/%0d/%0b",
                              n_recv, want.led, want.tone_hz, want.sound_active,
                              rsp_data.led, rsp_data.tone_hz, rsp_data.sound_active);
                  n_bad++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
   end

   always @(posedge clock) begin : watchdog
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int pick;
      int len;
      int song;
      bit mid_pause;
      mid_pause = 1'b0;

      // directed: field extremes, every action, the ignored codes and restarts
      queue_event(ACT_TICK, 32767, 7, 1'b1);
      queue_event(ACT_LED_ON, 0, 0, 1'b0);
      queue_event(ACT_LED_OFF, 32767, 7, 1'b1);
      queue_event(ACT_LED_ON, 0, 0, 1'b0);
      queue_event(ACT_BLINK_ON, 0, 7, 1'b1);
      queue_event(ACT_BLINK_ON, 32767, 0, 1'b0);
      queue_event(ACT_BLINK_OFF, 32767, 7, 1'b1);
      queue_event(3'd6, 32767, 7, 1'b1);
      queue_event(3'd7, 0, 0, 1'b0);
      queue_event(ACT_BEEP, 32767, 7, 1'b1);
      queue_event(ACT_BEEP, 0, 0, 1'b0);
      queue_event(ACT_TICK, 0, 0, 1'b0);
      queue_event(ACT_BEEP, 32767, 1, 1'b1);
      queue_event(ACT_BEEP, 0, 2, 1'b0);
      queue_event(ACT_BEEP, 32767, 3, 1'b1);
      queue_event(ACT_BEEP, 0, 4, 1'b0);
      queue_event(ACT_BEEP, 32767, 5, 1'b1);
      queue_event(ACT_BEEP, 0, 6, 1'b1);
      queue_event(ACT_BLINK_ON, 32767, 0, 1'b0);
      queue_event(ACT_LED_OFF, 0, 0, 1'b0);
      queue_event(ACT_BLINK_OFF, 0, 0, 1'b0);
      queue_event(ACT_TICK, 32767, 7, 1'b1);

      // random: mostly beeps played out by ticks, some blink runs, some noise
      pause_next = 1'b1;
      while (n_fed < ITEM_GOAL) begin
         if (!mid_pause && n_fed >= ITEM_GOAL / 2) begin
            pause_next = 1'b1;
            mid_pause = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            song = $urandom_range(0, 15);
            song = (song >= 14) ? 4 : ((song % 7 == 4) ? 0 : song % 7);
            queue_event(ACT_BEEP, $urandom_range(0, 32767), song,
                        1'($urandom_range(0, 1)));
            len = (song == 4) ? $urandom_range(1300, 1360) : $urandom_range(60, 380);
            for (int k = 0; k < len && n_fed < ITEM_GOAL + 100; k++) begin
               if ($urandom_range(0, 39) == 0) queue_stray();
               else queue_tick();
            end
         end else if (pick < 80) begin
            queue_event(ACT_BLINK_ON,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(1, 25),
                        $urandom_range(0, 7), 1'($urandom_range(0, 1)));
            len = $urandom_range(20, 150);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 29) == 0) queue_stray();
               else queue_tick();
            end
         end else if (pick < 90) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 2) == 0)
                  queue_event(ACT_BEEP, $urandom_range(0, 32767), 7,
                              1'($urandom_range(0, 1)));
               else
                  queue_event(3'($urandom_range(6, 7)), $urandom_range(0, 32767),
                              $urandom_range(0, 7), 1'($urandom_range(0, 1)));
            end
         end else begin
            queue_stray();
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) queue_tick();
         end
      end
      n_total = pending_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (n_sent < n_total || n_recv < n_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      if (n_bad == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
